[rtl/core/hrc_pkg.sv]
// hrc_pkg: shared constants and types for the hsl to rgb converter
// fixed-point units are 3*2^16 per full turn or full intensity
// no dependencies
package hrc_pkg;

  localparam int NUM_STAGES = 5;

  localparam int HUE_W  = 18;  // hue position in units of 1/196608 turn
  localparam int TMP_W  = 16;  // temporaries divided by three
  localparam int WGT_W  = 18;  // segment weight, 0 .. full
  localparam int PROD_W = 34;  // weight times temporary spread
  localparam int SCL_W  = 41;  // accumulated value times 85

  localparam logic [HUE_W-1:0] UNIT_FULL   = 18'd196608;
  localparam logic [HUE_W-1:0] UNIT_THIRD  = 18'd65536;
  localparam logic [HUE_W-1:0] UNIT_SIXTH  = 18'd32768;
  localparam logic [HUE_W-1:0] UNIT_HALF   = 18'd98304;
  localparam logic [HUE_W-1:0] UNIT_TWO3RD = 18'd131072;

  // per-stage advance enables, one bit per pipeline stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

[rtl/core/hrc_chan.sv]
// hrc_chan: one color channel, pipeline stages two to five
// weight select, spread multiply, accumulate and scale by 255
// depends on hrc_pkg
module hrc_chan import hrc_pkg::*; (
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  logic [HUE_W-1:0] hue_pos,
  input  logic [TMP_W-1:0] tmp1,
  input  logic [TMP_W-1:0] tmp2,
  output logic [7:0]       value
);

  logic [WGT_W-1:0]  wgt_next;
  logic [HUE_W-1:0]  down_dist;
  logic [WGT_W-1:0]  wgt;
  logic [TMP_W-1:0]  spread;
  logic [TMP_W-1:0]  tmp1_s2;
  logic [PROD_W-1:0] prod;
  logic [TMP_W-1:0]  tmp1_s3;
  logic [PROD_W-1:0] acc;
  logic [HUE_W-1:0]  tmp1_x3;
  logic [SCL_W-1:0]  scaled;

  // ramp up, flat high, ramp down, flat low
  always_comb begin
    down_dist = UNIT_TWO3RD - hue_pos;
    if (hue_pos < UNIT_SIXTH) begin
      wgt_next = WGT_W'({3'b000, hue_pos[14:0]} * 18'd6);
    end else if (hue_pos < UNIT_HALF) begin
      wgt_next = UNIT_FULL;
    end else if (hue_pos < UNIT_TWO3RD) begin
      wgt_next = WGT_W'(down_dist * 18'd6);
    end else begin
      wgt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      wgt     <= wgt_next;
      spread  <= tmp2 - tmp1;
      tmp1_s2 <= tmp1;
    end
    if (ctl.en[2]) begin
      prod    <= PROD_W'(spread) * PROD_W'(wgt);
      tmp1_s3 <= tmp1_s2;
    end
    if (ctl.en[3]) begin
      acc <= {tmp1_x3, 16'h0000} + prod;
    end
    if (ctl.en[4]) begin
      value <= scaled[39:32];
    end
  end

  assign tmp1_x3 = HUE_W'(tmp1_s3) * 18'd3;

  // 85 = 64 + 16 + 4 + 1
  assign scaled = {1'b0, acc, 6'b0} + {3'b0, acc, 4'b0}
                + {5'b0, acc, 2'b0} + {7'b0, acc};

endmodule

[rtl/core/hsl_to_rgb_convert.sv]
// hsl_to_rgb_convert: 8-bit hsl to 8-bit rgb pixel converter, top level
// stage one forms the temporaries and hue positions, hrc_chan does the rest
// depends on hrc_pkg and hrc_chan
//
//   channel   dir  tdata fields (low bit up)
//   s_axis    in   hue[7:0] saturation[15:8] lightness[23:16]
//   m_axis    out  red[7:0] green[15:8] blue[23:16]
//
// one pixel per clock through five register stages while the output is not
// stalled; an accepted word passes each stage in turn on its way to m_axis
// each of the five stages holds its own valid bit; a stage advances when it
// is empty or the next stage advances, so bubbles close up under stall and
// input is taken while a result waits at the output if a stage is empty
// rst clears the valid bits only; data registers are not reset
module hsl_to_rgb_convert import hrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hue, saturation, lightness
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red, green, blue
);

  logic [NUM_STAGES-1:0] valid;
  pipe_ctl_t             ctl;

  logic [7:0]        hue;
  logic [7:0]        sat;
  logic [7:0]        lgt;
  logic [15:0]       lxs;
  logic [16:0]       tmp2_full;
  logic [16:0]       tmp1_full;
  logic [HUE_W-1:0]  hue_grn;
  logic [HUE_W-1:0]  hue_red_raw;
  logic [HUE_W-1:0]  hue_red_next;
  logic [HUE_W-1:0]  hue_blu_next;

  logic [TMP_W-1:0]  tmp1;
  logic [TMP_W-1:0]  tmp2;
  logic [HUE_W-1:0]  pos_red;
  logic [HUE_W-1:0]  pos_grn;
  logic [HUE_W-1:0]  pos_blu;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;

  always_comb begin
    ctl.en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctl.en[k] = !valid[k] || ctl.en[k+1];
    end
  end

  assign s_axis_tready = ctl.en[0];
  assign m_axis_tvalid = valid[NUM_STAGES-1];
  assign m_axis_tdata  = {blue, green, red};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ctl.en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // temporaries divided by three: t2 = l*(256+s) or 256*(l+s) - l*s
  assign hue = s_axis_tdata[7:0];
  assign sat = s_axis_tdata[15:8];
  assign lgt = s_axis_tdata[23:16];
  assign lxs = lgt * sat;

  always_comb begin
    if (!lgt[7]) begin
      tmp2_full = {1'b0, lgt, 8'h00} + {1'b0, lxs};
    end else begin
      tmp2_full = {({1'b0, lgt} + {1'b0, sat}), 8'h00} - {1'b0, lxs};
    end
    tmp1_full = {lgt, 9'h000} - tmp2_full;
  end

  // hue times 768, offset by a third of a turn and wrapped
  assign hue_grn     = {1'b0, hue, 9'h000} + {2'b00, hue, 8'h00};
  assign hue_red_raw = hue_grn + UNIT_THIRD;

  always_comb begin
    if (hue_red_raw > UNIT_FULL) begin
      hue_red_next = hue_red_raw - UNIT_FULL;
    end else begin
      hue_red_next = hue_red_raw;
    end
    if (hue_grn < UNIT_THIRD) begin
      hue_blu_next = hue_grn + UNIT_TWO3RD;
    end else begin
      hue_blu_next = hue_grn - UNIT_THIRD;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      tmp1    <= tmp1_full[15:0];
      tmp2    <= tmp2_full[15:0];
      pos_red <= hue_red_next;
      pos_grn <= hue_grn;
      pos_blu <= hue_blu_next;
    end
  end

  hrc_chan u_red (
    .clk     (clk),
    .ctl     (ctl),
    .hue_pos (pos_red),
    .tmp1    (tmp1),
    .tmp2    (tmp2),
    .value   (red)
  );

  hrc_chan u_green (
    .clk     (clk),
    .ctl     (ctl),
    .hue_pos (pos_grn),
    .tmp1    (tmp1),
    .tmp2    (tmp2),
    .value   (green)
  );

  hrc_chan u_blue (
    .clk     (clk),
    .ctl     (ctl),
    .hue_pos (pos_blu),
    .tmp1    (tmp1),
    .tmp2    (tmp2),
    .value   (blue)
  );

`ifndef ASSERT_OFF
  // a taken output frees the whole chain
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output was taken");

  // in-flight count grows by one on input only
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
    |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("accepted word lost in pipeline");

  // in-flight count drops by one on output only
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(s_axis_tvalid && s_axis_tready) && m_axis_tvalid && m_axis_tready)
    |=> $countones(valid) == $past($countones(valid)) - 1)
    else $error("delivered word repeated in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
